>>> rtl/nmea_pkg.sv
package nmea_pkg;

  // Default body length limit in characters, between '$' and '*'.
  localparam int MAX_LINE_LEN_DEF = 128;

  // Depth of the queue between the framing front end and the field back end.
  localparam int QUEUE_DEPTH = 2;

  // Character codes.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_N      = 8'h4e;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;

  // Sentence headers, first character in the top byte.
  localparam logic [47:0] HDR_RMC = "GNRMC,";
  localparam logic [47:0] HDR_GGA = "GNGGA,";
  localparam logic [2:0]  HDR_LEN = 3'd6;

  // Record kinds.
  localparam logic [1:0] KIND_RMC = 2'd1;
  localparam logic [1:0] KIND_GGA = 2'd2;

  // Field bookkeeping.
  localparam logic [3:0] COMMAS_NEED = 4'd11;

  // Gates on the integer part of numeric fields.
  localparam logic [15:0] LAT_LIMIT   = 16'd9000;
  localparam logic [15:0] LON_LIMIT   = 16'd18000;
  localparam logic [15:0] SPEED_LIMIT = 16'd138;
  localparam logic [15:0] COURSE_LIMIT = 16'd361;
  localparam logic [7:0]  ALT_SIGN    = 8'h2d;

  // Events passed from the front end to the back end.
  typedef enum logic [1:0] {
    EV_START,
    EV_BODY,
    EV_END
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
  } ev_t;

  // Position in the sentence tail.
  typedef enum logic [2:0] {
    TP_BODY,
    TP_HEX1,
    TP_HEX2,
    TP_CR,
    TP_TAIL
  } tail_phase_t;

  // One result record.
  typedef struct packed {
    logic [1:0]  sentence_kind;
    logic [47:0] date_time;
    logic        fix_invalid;
    logic [1:0]  hemispheres;
    logic [31:0] latitude_bcd;
    logic [39:0] longitude_bcd;
    logic [23:0] speed_bcd;
    logic [23:0] course_bcd;
    logic [6:0]  satellites;
    logic [31:0] altitude_bcd;
  } rec_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Header character at a given position, first character at position zero.
  function automatic logic [7:0] hdr_char(input logic [47:0] hdr, input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = hdr[47:40];
      3'd1:    c = hdr[39:32];
      3'd2:    c = hdr[31:24];
      3'd3:    c = hdr[23:16];
      3'd4:    c = hdr[15:8];
      default: c = hdr[7:0];
    endcase
    return c;
  endfunction

endpackage

>>> rtl/nmea_in_if.sv
interface nmea_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/nmea_out_if.sv
interface nmea_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  sentence_kind;
  logic [47:0] date_time;
  logic        fix_invalid;
  logic [1:0]  hemispheres;
  logic [31:0] latitude_bcd;
  logic [39:0] longitude_bcd;
  logic [23:0] speed_bcd;
  logic [23:0] course_bcd;
  logic [6:0]  satellites;
  logic [31:0] altitude_bcd;

  modport source (
    output valid, input ready,
    output sentence_kind, output date_time, output fix_invalid, output hemispheres,
    output latitude_bcd, output longitude_bcd, output speed_bcd, output course_bcd,
    output satellites, output altitude_bcd
  );
  modport sink (
    input valid, output ready,
    input sentence_kind, input date_time, input fix_invalid, input hemispheres,
    input latitude_bcd, input longitude_bcd, input speed_bcd, input course_bcd,
    input satellites, input altitude_bcd
  );
endinterface

>>> rtl/nmea_front.sv
module nmea_front #(
  parameter int MAX_LINE_LEN = nmea_pkg::MAX_LINE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     rx_byte,
  input  logic           q_ready,
  output logic           push,
  output nmea_pkg::ev_t  push_ev
);

  localparam int LW = $clog2(MAX_LINE_LEN + 1);

  logic                  in_sent_r, in_sent_nxt;
  logic [7:0]            xor_r, xor_nxt;
  logic [7:0]            chk_r, chk_nxt;
  logic [LW-1:0]         blen_r, blen_nxt;
  nmea_pkg::tail_phase_t phase_r, phase_nxt;
  logic                  tbad_r, tbad_nxt;

  logic       accept;
  logic       hex_ok;
  logic [3:0] hex_v;
  logic       tail_ok;
  logic       body_full;

  assign in_ready  = q_ready;
  assign accept    = in_valid && q_ready;
  assign body_full = (blen_r >= LW'(MAX_LINE_LEN));
  assign tail_ok   = !tbad_r && ((phase_r == nmea_pkg::TP_CR) || (phase_r == nmea_pkg::TP_TAIL))
                     && (chk_r == xor_r);

  // Hex digit decode for the checksum.
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (nmea_pkg::is_digit(rx_byte)) begin
      hex_v = rx_byte[3:0];
    end else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) ||
                 (rx_byte >= 8'h61 && rx_byte <= 8'h66)) begin
      hex_v = rx_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Framing state: next values.
  always_comb begin
    in_sent_nxt = in_sent_r;
    xor_nxt     = xor_r;
    chk_nxt     = chk_r;
    blen_nxt    = blen_r;
    phase_nxt   = phase_r;
    tbad_nxt    = tbad_r;
    if (accept) begin
      if (rx_byte == nmea_pkg::CH_DOLLAR) begin
        in_sent_nxt = 1'b1;
        xor_nxt     = 8'd0;
        chk_nxt     = 8'd0;
        blen_nxt    = '0;
        phase_nxt   = nmea_pkg::TP_BODY;
        tbad_nxt    = 1'b0;
      end else if (in_sent_r) begin
        if (rx_byte == nmea_pkg::CH_LF) begin
          in_sent_nxt = 1'b0;
        end else begin
          unique case (phase_r)
            nmea_pkg::TP_BODY: begin
              if (rx_byte == nmea_pkg::CH_STAR) begin
                phase_nxt = nmea_pkg::TP_HEX1;
              end else if (body_full) begin
                in_sent_nxt = 1'b0;
              end else begin
                blen_nxt = blen_r + LW'(1);
                xor_nxt  = xor_r ^ rx_byte;
              end
            end
            nmea_pkg::TP_HEX1, nmea_pkg::TP_HEX2: begin
              if (!hex_ok) begin
                tbad_nxt = 1'b1;
              end else begin
                chk_nxt   = {chk_r[3:0], hex_v};
                phase_nxt = (phase_r == nmea_pkg::TP_HEX1) ? nmea_pkg::TP_HEX2
                                                            : nmea_pkg::TP_CR;
              end
            end
            nmea_pkg::TP_CR: begin
              if (rx_byte == nmea_pkg::CH_CR) begin
                phase_nxt = nmea_pkg::TP_TAIL;
              end else begin
                tbad_nxt = 1'b1;
              end
            end
            default: begin
              tbad_nxt = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Events toward the back end.
  always_comb begin
    push         = 1'b0;
    push_ev.kind = nmea_pkg::EV_BODY;
    push_ev.data = rx_byte;
    if (accept) begin
      if (rx_byte == nmea_pkg::CH_DOLLAR) begin
        push         = 1'b1;
        push_ev.kind = nmea_pkg::EV_START;
      end else if (in_sent_r && rx_byte == nmea_pkg::CH_LF) begin
        push         = tail_ok;
        push_ev.kind = nmea_pkg::EV_END;
      end else if (in_sent_r && phase_r == nmea_pkg::TP_BODY &&
                   rx_byte != nmea_pkg::CH_STAR && !body_full) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0;
      xor_r     <= 8'd0;
      chk_r     <= 8'd0;
      blen_r    <= '0;
      phase_r   <= nmea_pkg::TP_BODY;
      tbad_r    <= 1'b0;
    end else begin
      in_sent_r <= in_sent_nxt;
      xor_r     <= xor_nxt;
      chk_r     <= chk_nxt;
      blen_r    <= blen_nxt;
      phase_r   <= phase_nxt;
      tbad_r    <= tbad_nxt;
    end
  end

  // A line feed always closes the sentence.
  a_lf_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && rx_byte == nmea_pkg::CH_LF) |=> !in_sent_r)
    else $error("sentence still open after line feed");

  // The stored body never grows past the limit.
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    blen_r <= LW'(MAX_LINE_LEN))
    else $error("body length beyond limit");

endmodule

>>> rtl/nmea_queue.sv
module nmea_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  nmea_pkg::ev_t push_ev,
  output logic          push_ready,
  output logic          pop_valid,
  output nmea_pkg::ev_t pop_ev,
  input  logic          pop
);

  localparam int DEPTH = nmea_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  nmea_pkg::ev_t  mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt;
  logic [PW-1:0]  rptr_r, rptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_ev     = mem_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_ev;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !push_ready))
    else $error("word pushed into full queue");

endmodule

>>> rtl/nmea_back.sv
module nmea_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ev_valid,
  input  nmea_pkg::ev_t  ev,
  output logic           ev_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output nmea_pkg::rec_t rec
);

  // Header and field tracking.
  logic [2:0] hdr_pos_r, hdr_pos_nxt;
  logic       rmc_ok_r, rmc_ok_nxt;
  logic       gga_ok_r, gga_ok_nxt;
  logic [3:0] fnum_r, fnum_nxt;

  // Per-field scanner.
  logic [6:0]  len_r, len_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        bad_r, bad_nxt;
  logic        dot_r, dot_nxt;
  logic        digits_r, digits_nxt;
  logic [15:0] ip_r, ip_nxt;
  logic [6:0]  pi_r, pi_nxt;
  logic [2:0]  aft_r, aft_nxt;
  logic        decnz_r, decnz_nxt;
  logic [7:0]  tenths_r, tenths_nxt;
  logic [43:0] sh_r, sh_nxt;
  logic [15:0] pre_r, pre_nxt;
  logic        sd_ok_r, sd_ok_nxt;
  logic [3:0]  prevd_r, prevd_nxt;
  logic [6:0]  pv_r [3];
  logic [6:0]  pv_nxt [3];

  // Finished field values.
  logic        tm_ok_r, tm_ok_nxt;
  logic [6:0]  tm_r [3];
  logic [6:0]  tm_nxt [3];
  logic        dt_ok_r, dt_ok_nxt;
  logic [6:0]  dt_r [3];
  logic [6:0]  dt_nxt [3];
  logic        fix_a_r, fix_a_nxt;
  logic        lat_ok_r, lat_ok_nxt;
  logic [31:0] lat_r, lat_nxt;
  logic        lon_ok_r, lon_ok_nxt;
  logic [39:0] lon_r, lon_nxt;
  logic        ns_ok_r, ns_ok_nxt;
  logic        north_r, north_nxt;
  logic        ew_ok_r, ew_ok_nxt;
  logic        west_r, west_nxt;
  logic [23:0] speed_r, speed_nxt;
  logic [6:0]  sats_r, sats_nxt;
  logic [23:0] course_r, course_nxt;
  logic [31:0] alt_r, alt_nxt;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  nmea_pkg::rec_t rec_r, rec_nxt;

  logic       ev_start, ev_body, ev_end;
  logic [7:0] b;
  logic [3:0] d;
  logic       isd;
  logic       in_fld, fld_comma, fld_char;
  logic       produce;
  logic [19:0] ip_x10;
  logic        num_ok;
  logic [23:0] speed_val, course_val;
  logic [6:0]  sats_val;
  logic [31:0] alt_val;
  logic        alt_sign;
  logic [6:0]  alt_cnt;
  logic [15:0] alt_mask;

  logic        date_ok;
  logic [7:0]  yy, mm, dd, hh, dim;
  logic [7:0]  o_yy, o_mm, o_dd, o_hh;
  logic        pos_ok;

  assign ev_pop   = ev_valid && ((ev.kind != nmea_pkg::EV_END) || !out_valid_r || out_ready);
  assign ev_start = ev_pop && ev.kind == nmea_pkg::EV_START;
  assign ev_body  = ev_pop && ev.kind == nmea_pkg::EV_BODY;
  assign ev_end   = ev_pop && ev.kind == nmea_pkg::EV_END;
  assign b        = ev.data;
  assign d        = b[3:0] - nmea_pkg::CH_ZERO[3:0];
  assign isd      = nmea_pkg::is_digit(b);
  assign in_fld   = (hdr_pos_r == nmea_pkg::HDR_LEN);
  assign fld_comma = ev_body && in_fld && b == nmea_pkg::CH_COMMA;
  assign fld_char  = ev_body && in_fld && b != nmea_pkg::CH_COMMA;
  assign produce   = ev_end && in_fld && (rmc_ok_r || gga_ok_r) &&
                     (fnum_r >= nmea_pkg::COMMAS_NEED);

  assign ip_x10 = {1'b0, ip_r, 3'b000} + {3'b000, ip_r, 1'b0} + {16'd0, d};

  // Header match and comma count.
  always_comb begin
    hdr_pos_nxt = hdr_pos_r;
    rmc_ok_nxt  = rmc_ok_r;
    gga_ok_nxt  = gga_ok_r;
    fnum_nxt    = fnum_r;
    if (ev_start) begin
      hdr_pos_nxt = 3'd0;
      rmc_ok_nxt  = 1'b1;
      gga_ok_nxt  = 1'b1;
      fnum_nxt    = 4'd0;
    end else if (ev_body && !in_fld) begin
      hdr_pos_nxt = hdr_pos_r + 3'd1;
      rmc_ok_nxt  = rmc_ok_r && (b == nmea_pkg::hdr_char(nmea_pkg::HDR_RMC, hdr_pos_r));
      gga_ok_nxt  = gga_ok_r && (b == nmea_pkg::hdr_char(nmea_pkg::HDR_GGA, hdr_pos_r));
    end else if (fld_comma && fnum_r < nmea_pkg::COMMAS_NEED) begin
      fnum_nxt = fnum_r + 4'd1;
    end
  end

  // Field scanner: one character per step.
  always_comb begin
    len_nxt    = len_r;
    first_nxt  = first_r;
    bad_nxt    = bad_r;
    dot_nxt    = dot_r;
    digits_nxt = digits_r;
    ip_nxt     = ip_r;
    pi_nxt     = pi_r;
    aft_nxt    = aft_r;
    decnz_nxt  = decnz_r;
    tenths_nxt = tenths_r;
    sh_nxt     = sh_r;
    pre_nxt    = pre_r;
    sd_ok_nxt  = sd_ok_r;
    prevd_nxt  = prevd_r;
    pv_nxt     = pv_r;
    if (ev_start || fld_comma) begin
      len_nxt    = 7'd0;
      first_nxt  = 8'd0;
      bad_nxt    = 1'b0;
      dot_nxt    = 1'b0;
      digits_nxt = 1'b0;
      ip_nxt     = 16'd0;
      pi_nxt     = 7'd0;
      aft_nxt    = 3'd0;
      decnz_nxt  = 1'b0;
      tenths_nxt = 8'd0;
      sh_nxt     = 44'd0;
      pre_nxt    = 16'd0;
      sd_ok_nxt  = 1'b1;
      prevd_nxt  = 4'd0;
    end else if (fld_char) begin
      if (len_r != 7'h7f) begin
        len_nxt = len_r + 7'd1;
      end
      if (len_r == 7'd0) begin
        first_nxt = b;
      end
      // Characters after the first dot.
      if (dot_r) begin
        if (aft_r == 3'd0) begin
          tenths_nxt = b - nmea_pkg::CH_ZERO;
        end
        if (aft_r != 3'd7) begin
          aft_nxt = aft_r + 3'd1;
        end
      end
      // Number syntax and integer part.
      if (b == nmea_pkg::CH_DOT) begin
        if (dot_r) begin
          bad_nxt = 1'b1;
        end else begin
          dot_nxt = 1'b1;
          pi_nxt  = len_r;
          pre_nxt = sh_r[15:0];
        end
      end else if (isd) begin
        digits_nxt = 1'b1;
        if (!dot_r) begin
          ip_nxt = (ip_x10 > 20'hffff) ? 16'hffff : ip_x10[15:0];
        end else if (aft_r < 3'd5 && d != 4'd0) begin
          decnz_nxt = 1'b1;
        end
      end else begin
        bad_nxt = 1'b1;
      end
      sh_nxt = {sh_r[39:0], d};
      // Leading six digits as three binary pairs.
      if (len_r < 7'd6) begin
        if (!isd) begin
          sd_ok_nxt = 1'b0;
        end
        if (!len_r[0]) begin
          prevd_nxt = d;
        end else begin
          pv_nxt[len_r[2:1]] = 7'({prevd_r, 3'b000}) + 7'({prevd_r, 1'b0}) + 7'(d);
        end
      end
    end
  end

  // Values of the field that ends at the current comma.
  always_comb begin
    num_ok = !bad_r && digits_r;
    speed_val = 24'd0;
    if (dot_r && pi_r != 7'd0) begin
      speed_val = {(pi_r <= 7'd4) ? pre_r : 16'd0, tenths_r};
    end
    course_val = 24'd0;
    if (dot_r && pi_r != 7'd0) begin
      course_val = {(pi_r <= 7'd3) ? pre_r : 16'd0, tenths_r};
    end
    sats_val = 7'd0;
    if (sd_ok_r && len_r == 7'd1) begin
      sats_val = {3'd0, first_r[3:0]};
    end else if (sd_ok_r && len_r == 7'd2) begin
      sats_val = pv_r[0];
    end
    alt_sign = (first_r == nmea_pkg::CH_MINUS);
    alt_cnt  = pi_r - {6'd0, alt_sign};
    case (alt_cnt)
      7'd1:    alt_mask = 16'h000f;
      7'd2:    alt_mask = 16'h00ff;
      7'd3:    alt_mask = 16'h0fff;
      7'd4:    alt_mask = 16'hffff;
      default: alt_mask = 16'h0000;
    endcase
    alt_val = 32'd0;
    if (len_r != 7'd0 && dot_r && pi_r != 7'd0) begin
      alt_val = {alt_sign ? nmea_pkg::ALT_SIGN : 8'd0, pre_r & alt_mask, tenths_r};
    end
  end

  // Store each finished field.
  always_comb begin
    tm_ok_nxt  = tm_ok_r;
    tm_nxt     = tm_r;
    dt_ok_nxt  = dt_ok_r;
    dt_nxt     = dt_r;
    fix_a_nxt  = fix_a_r;
    lat_ok_nxt = lat_ok_r;
    lat_nxt    = lat_r;
    lon_ok_nxt = lon_ok_r;
    lon_nxt    = lon_r;
    ns_ok_nxt  = ns_ok_r;
    north_nxt  = north_r;
    ew_ok_nxt  = ew_ok_r;
    west_nxt   = west_r;
    speed_nxt  = speed_r;
    sats_nxt   = sats_r;
    course_nxt = course_r;
    alt_nxt    = alt_r;
    if (fld_comma) begin
      case (fnum_r)
        4'd0: begin
          tm_ok_nxt = sd_ok_r && len_r >= 7'd6;
          tm_nxt    = pv_r;
        end
        4'd1: begin
          fix_a_nxt = len_r != 7'd0 && first_r == nmea_pkg::CH_A;
        end
        4'd2: begin
          lat_ok_nxt = num_ok && ((ip_r < nmea_pkg::LAT_LIMIT) ||
                                  (ip_r == nmea_pkg::LAT_LIMIT && !decnz_r));
          lat_nxt    = (len_r == 7'd10) ? {sh_r[39:24], sh_r[19:4]} : 32'd0;
        end
        4'd3: begin
          ns_ok_nxt = len_r != 7'd0 &&
                      (first_r == nmea_pkg::CH_N || first_r == nmea_pkg::CH_S);
          north_nxt = first_r == nmea_pkg::CH_N;
        end
        4'd4: begin
          lon_ok_nxt = num_ok && ((ip_r < nmea_pkg::LON_LIMIT) ||
                                  (ip_r == nmea_pkg::LON_LIMIT && !decnz_r));
          lon_nxt    = (len_r == 7'd11) ? {sh_r[43:24], sh_r[19:4]} : 40'd0;
        end
        4'd5: begin
          ew_ok_nxt = len_r != 7'd0 &&
                      (first_r == nmea_pkg::CH_E || first_r == nmea_pkg::CH_W);
          west_nxt  = first_r == nmea_pkg::CH_W;
        end
        4'd6: begin
          speed_nxt = (num_ok && ip_r <= nmea_pkg::SPEED_LIMIT) ? speed_val : 24'd0;
          sats_nxt  = sats_val;
        end
        4'd7: begin
          course_nxt = (num_ok && ip_r <= nmea_pkg::COURSE_LIMIT) ? course_val : 24'd0;
        end
        4'd8: begin
          dt_ok_nxt = sd_ok_r && len_r >= 7'd6;
          dt_nxt    = pv_r;
          alt_nxt   = alt_val;
        end
        default: begin
        end
      endcase
    end
  end

  // Date and time checks and the eight hour shift.
  always_comb begin
    dd = {1'b0, dt_r[0]};
    mm = {1'b0, dt_r[1]};
    yy = {1'b0, dt_r[2]};
    hh = {1'b0, tm_r[0]};
    date_ok = tm_ok_r && dt_ok_r && hh < 8'd24 && tm_r[1] < 7'd60 && tm_r[2] < 7'd60 &&
              yy >= 8'd14 && yy <= 8'd98 && mm >= 8'd1 && mm <= 8'd12 &&
              dd >= 8'd1 && dd <= 8'd31;
    case (mm) inside
      8'd2:                  dim = (yy[1:0] == 2'd0) ? 8'd29 : 8'd28;
      8'd4, 8'd6, 8'd9, 8'd11: dim = 8'd30;
      default:               dim = 8'd31;
    endcase
    o_yy = yy;
    o_mm = mm;
    o_dd = dd;
    o_hh = hh + 8'd8;
    if (hh >= 8'd16) begin
      o_hh = hh - 8'd16;
      o_dd = dd + 8'd1;
      if (o_dd > dim) begin
        o_dd = 8'd1;
        if (mm == 8'd12) begin
          o_mm = 8'd1;
          o_yy = yy + 8'd1;
        end else begin
          o_mm = mm + 8'd1;
        end
      end
    end
  end

  // Record assembly into the output register.
  always_comb begin
    pos_ok        = lat_ok_r && lon_ok_r && ns_ok_r && ew_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rec_nxt       = rec_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
      rec_nxt       = '0;
      rec_nxt.fix_invalid = 1'b1;
      if (rmc_ok_r) begin
        rec_nxt.sentence_kind = nmea_pkg::KIND_RMC;
        if (date_ok) begin
          rec_nxt.date_time = {o_yy, o_mm, o_dd, o_hh, 1'b0, tm_r[1], 1'b0, tm_r[2]};
        end
        rec_nxt.fix_invalid = !fix_a_r;
        if (pos_ok) begin
          rec_nxt.hemispheres   = {west_r, north_r};
          rec_nxt.latitude_bcd  = lat_r;
          rec_nxt.longitude_bcd = lon_r;
        end
        rec_nxt.speed_bcd  = speed_r;
        rec_nxt.course_bcd = course_r;
      end else begin
        rec_nxt.sentence_kind = nmea_pkg::KIND_GGA;
        rec_nxt.satellites    = sats_r;
        rec_nxt.altitude_bcd  = alt_r;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= nmea_pkg::HDR_LEN;
      rmc_ok_r    <= 1'b0;
      gga_ok_r    <= 1'b0;
      fnum_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      hdr_pos_r   <= hdr_pos_nxt;
      rmc_ok_r    <= rmc_ok_nxt;
      gga_ok_r    <= gga_ok_nxt;
      fnum_r      <= fnum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scanner and field payload.
  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    first_r  <= first_nxt;
    bad_r    <= bad_nxt;
    dot_r    <= dot_nxt;
    digits_r <= digits_nxt;
    ip_r     <= ip_nxt;
    pi_r     <= pi_nxt;
    aft_r    <= aft_nxt;
    decnz_r  <= decnz_nxt;
    tenths_r <= tenths_nxt;
    sh_r     <= sh_nxt;
    pre_r    <= pre_nxt;
    sd_ok_r  <= sd_ok_nxt;
    prevd_r  <= prevd_nxt;
    pv_r     <= pv_nxt;
    tm_ok_r  <= tm_ok_nxt;
    tm_r     <= tm_nxt;
    dt_ok_r  <= dt_ok_nxt;
    dt_r     <= dt_nxt;
    fix_a_r  <= fix_a_nxt;
    lat_ok_r <= lat_ok_nxt;
    lat_r    <= lat_nxt;
    lon_ok_r <= lon_ok_nxt;
    lon_r    <= lon_nxt;
    ns_ok_r  <= ns_ok_nxt;
    north_r  <= north_nxt;
    ew_ok_r  <= ew_ok_nxt;
    west_r   <= west_nxt;
    speed_r  <= speed_nxt;
    sats_r   <= sats_nxt;
    course_r <= course_nxt;
    alt_r    <= alt_nxt;
    rec_r    <= rec_nxt;
  end

  assign out_valid = out_valid_r;
  assign rec       = rec_r;

  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (rec_r.sentence_kind == nmea_pkg::KIND_RMC ||
                     rec_r.sentence_kind == nmea_pkg::KIND_GGA))
    else $error("record with unknown kind");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ev_start |=> (hdr_pos_r == 3'd0 && fnum_r == 4'd0))
    else $error("start word did not clear header tracking");

  a_record_loads: assert property (@(posedge clk) disable iff (!rst_n)
    produce |=> out_valid_r)
    else $error("finished record not presented");

endmodule

>>> rtl/nmea_rmc_gga_field_extractor.sv
// NMEA RMC/GGA field extractor: takes one received character per cycle and
// gives one record for each good $GNRMC or $GNGGA sentence at its line feed.
// The framing front end checks the checksum and body length, and passes
// start, body and end words through a two-entry queue to the field back end,
// which parses fields one character per cycle and holds the finished record
// in an output register. A character is accepted every cycle while the queue
// has room; the only stall comes at the end word of a sentence with a good
// tail while an earlier record has not been taken yet. The end word passes
// through the queue before the record is loaded into the output register.
module nmea_rmc_gga_field_extractor #(
  parameter int MAX_LINE_LEN = nmea_pkg::MAX_LINE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  nmea_in_if.sink     in_ch,
  nmea_out_if.source  out_ch
);

  logic           push, push_ready;
  nmea_pkg::ev_t  push_ev;
  logic           pop_valid, pop;
  nmea_pkg::ev_t  pop_ev;
  nmea_pkg::rec_t rec;

  nmea_front #(
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .rx_byte  (in_ch.rx_byte),
    .q_ready  (push_ready),
    .push     (push),
    .push_ev  (push_ev)
  );

  nmea_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ev    (push_ev),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ev     (pop_ev),
    .pop        (pop)
  );

  nmea_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (pop_valid),
    .ev        (pop_ev),
    .ev_pop    (pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .rec       (rec)
  );

  // Result fields.
  assign out_ch.sentence_kind = rec.sentence_kind;
  assign out_ch.date_time     = rec.date_time;
  assign out_ch.fix_invalid   = rec.fix_invalid;
  assign out_ch.hemispheres   = rec.hemispheres;
  assign out_ch.latitude_bcd  = rec.latitude_bcd;
  assign out_ch.longitude_bcd = rec.longitude_bcd;
  assign out_ch.speed_bcd     = rec.speed_bcd;
  assign out_ch.course_bcd    = rec.course_bcd;
  assign out_ch.satellites    = rec.satellites;
  assign out_ch.altitude_bcd  = rec.altitude_bcd;

endmodule

>>> tb/nmea_rmc_gga_field_extractor_tb.sv
`default_nettype none

module nmea_rmc_gga_field_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nmea_pkg::*;

  // Ways to damage the tail of a sentence.
  typedef enum int {
    TL_GOOD,
    TL_BAD_SUM,
    TL_LOWER_NO_CR,
    TL_EXTRA,
    TL_BAD_HEX,
    TL_NO_STAR
  } tail_style_t;

  // Record predictor and store of expected records.
  class nmea_scoreboard;
    localparam int MAXL = MAX_LINE_LEN_DEF;

    bit          in_sent;
    bit [7:0]    xsum;
    bit [7:0]    sum_rx;
    int          blen;
    tail_phase_t tphase;
    bit          tail_bad;
    bit [7:0]    body[MAXL];
    rec_t        expected_recs[$];
    int          errors;
    int          records_seen;

    function int pending();
      return expected_recs.size();
    endfunction

    function bit is_dig(bit [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function int hex_of(bit [7:0] c);
      if (is_dig(c)) return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
    endfunction

    // Digits and at most one dot, with at least one digit.
    function bit parse_num(int s, int n, output longint unsigned ip, output int dot);
      int digits;
      bit seen;
      longint unsigned v;
      bit [7:0] c;
      digits = 0;
      seen = 0;
      v = 0;
      dot = n;
      ip = 0;
      for (int k = 0; k < n; k++) begin
        c = body[s + k];
        if (c == CH_DOT) begin
          if (seen) return 0;
          seen = 1;
          dot = k;
        end else if (is_dig(c)) begin
          digits++;
          if (!seen) begin
            v = v * 10 + (c - "0");
            if (v > 9999999) v = 9999999;
          end
        end else begin
          return 0;
        end
      end
      ip = v;
      return digits > 0;
    endfunction

    // Scaled angle used by the position range gate.
    function longint unsigned angle_of(int s, int n, longint unsigned ip, int dot);
      longint unsigned deg, mins;
      int idx;
      deg = ip / 100;
      mins = ip % 100;
      for (int k = 0; k < 5; k++) begin
        idx = dot + 1 + k;
        mins = mins * 10 + ((idx < n) ? longint'(body[s + idx] - "0") : 0);
      end
      return (deg * 10000000 + (mins + 5) * 5 / 3) / 10;
    endfunction

    function int dot_pos(int s, int n);
      for (int k = 0; k < n; k++)
        if (body[s + k] == CH_DOT) return k;
      return n;
    endfunction

    function bit [15:0] int_digits(int s, int pi, int cnt, int maxcnt);
      bit [15:0] v;
      v = 0;
      if (cnt == 0 || cnt > maxcnt) return 0;
      for (int k = 0; k < cnt; k++) v |= 16'(body[s + pi - 1 - k][3:0]) << (4 * k);
      return v;
    endfunction

    function bit [23:0] decimal_bcd(int s, int n, int maxcnt);
      int pi;
      bit [7:0] tenths;
      pi = dot_pos(s, n);
      tenths = 0;
      if (pi == 0 || pi >= n) return 0;
      if (pi + 1 < n) tenths = body[s + pi + 1] - 8'h30;
      return {int_digits(s, pi, pi, maxcnt), tenths};
    endfunction

    function bit [31:0] altitude_bcd(int s, int n);
      int pi, cnt;
      bit [7:0] tenths, sign;
      pi = dot_pos(s, n);
      tenths = 0;
      sign = 0;
      cnt = pi;
      if (pi == 0 || pi >= n) return 0;
      if (body[s] == CH_MINUS) begin
        sign = ALT_SIGN;
        cnt = pi - 1;
      end
      if (pi + 1 < n) tenths = body[s + pi + 1] - 8'h30;
      return {sign, int_digits(s, pi, cnt, 4), tenths};
    endfunction

    function bit six_dig(int s, int n, output int a, output int b, output int c);
      a = 0;
      b = 0;
      c = 0;
      if (n < 6) return 0;
      for (int k = 0; k < 6; k++)
        if (!is_dig(body[s + k])) return 0;
      a = (body[s] - "0") * 10 + (body[s + 1] - "0");
      b = (body[s + 2] - "0") * 10 + (body[s + 3] - "0");
      c = (body[s + 4] - "0") * 10 + (body[s + 5] - "0");
      return 1;
    endfunction

    // Builds the record of a finished sentence; returns 0 when none is due.
    function bit build_record(output rec_t r);
      int n, cnt, dim;
      int commas[11];
      int fs[9];
      int fl[9];
      int t[6];
      int hh, mi, ss, dd, mo, yy;
      longint unsigned ilat, ilon, ip;
      int dlat, dlon, dot, a, o, sp;
      bit [7:0] ns, ew;
      r = '0;
      if (blen < 6) return 0;
      if ({body[0], body[1], body[2], body[3], body[4], body[5]} == HDR_RMC)
        r.sentence_kind = KIND_RMC;
      else if ({body[0], body[1], body[2], body[3], body[4], body[5]} == HDR_GGA)
        r.sentence_kind = KIND_GGA;
      else
        return 0;
      n = blen - 6;
      cnt = 0;
      for (int k = 0; k < n && cnt < 11; k++)
        if (body[6 + k] == CH_COMMA) commas[cnt++] = k;
      if (cnt < 11) return 0;
      for (int k = 0; k < 9; k++) begin
        fs[k] = 6 + ((k == 0) ? 0 : commas[k - 1] + 1);
        fl[k] = commas[k] + 6 - fs[k];
      end
      r.fix_invalid = 1'b1;

      if (r.sentence_kind == KIND_RMC) begin
        // Time and date, shifted by eight hours with calendar rollover.
        if (six_dig(fs[0], fl[0], hh, mi, ss) && six_dig(fs[8], fl[8], dd, mo, yy) &&
            hh < 24 && mi < 60 && ss < 60 && yy >= 14 && yy <= 98 &&
            mo >= 1 && mo <= 12 && dd >= 1 && dd <= 31) begin
          t = '{yy, mo, dd, hh, mi, ss};
          if (t[3] < 16) begin
            t[3] += 8;
          end else begin
            t[3] = (t[3] + 8) % 24;
            t[2] += 1;
            if (t[1] == 2) dim = (t[0] % 4 == 0) ? 29 : 28;
            else if (t[1] == 4 || t[1] == 6 || t[1] == 9 || t[1] == 11) dim = 30;
            else dim = 31;
            if (t[2] > dim) begin
              t[2] = 1;
              if (t[1] == 12) begin
                t[1] = 1;
                t[0] += 1;
              end else begin
                t[1] += 1;
              end
            end
          end
          r.date_time = {t[0][7:0], t[1][7:0], t[2][7:0], t[3][7:0], t[4][7:0], t[5][7:0]};
        end
        r.fix_invalid = !(fl[1] > 0 && body[fs[1]] == CH_A);

        // Position with hemisphere and range gates.
        ns = body[fs[3]];
        ew = body[fs[5]];
        a = fs[2];
        o = fs[4];
        if (fl[2] > 0 && fl[4] > 0 && fl[3] > 0 && fl[5] > 0 &&
            (ns == CH_N || ns == CH_S) && (ew == CH_E || ew == CH_W) &&
            parse_num(a, fl[2], ilat, dlat) && parse_num(o, fl[4], ilon, dlon) &&
            angle_of(a, fl[2], ilat, dlat) <= 90000000 &&
            angle_of(o, fl[4], ilon, dlon) <= 180000000) begin
          r.hemispheres = {ew == CH_W, ns == CH_N};
          if (fl[2] == 10)
            r.latitude_bcd = {body[a][3:0], body[a+1][3:0], body[a+2][3:0], body[a+3][3:0],
                              body[a+5][3:0], body[a+6][3:0], body[a+7][3:0],
                              body[a+8][3:0]};
          if (fl[4] == 11)
            r.longitude_bcd = {4'h0, body[o][3:0], body[o+1][3:0], body[o+2][3:0],
                               body[o+3][3:0], body[o+4][3:0], body[o+6][3:0],
                               body[o+7][3:0], body[o+8][3:0], body[o+9][3:0]};
        end
        sp = fs[6];
        if (fl[6] > 0 && parse_num(sp, fl[6], ip, dot) && ip * 1852 / 1000 <= 255)
          r.speed_bcd = decimal_bcd(sp, fl[6], 4);
        if (fl[7] > 0 && parse_num(fs[7], fl[7], ip, dot) && ip / 2 <= 180)
          r.course_bcd = decimal_bcd(fs[7], fl[7], 3);
      end else begin
        // Satellite count and altitude.
        if (fl[6] >= 1 && fl[6] <= 2 && is_dig(body[fs[6]]) &&
            (fl[6] == 1 || is_dig(body[fs[6] + 1])))
          r.satellites = (fl[6] == 1) ? 7'(body[fs[6]] - "0")
                                      : 7'((body[fs[6]] - "0") * 10 + body[fs[6] + 1] - "0");
        if (fl[8] > 0) r.altitude_bcd = altitude_bcd(fs[8], fl[8]);
      end
      return 1;
    endfunction

    // Notes one accepted character.
    function void note_byte(bit [7:0] b);
      int h;
      rec_t r;
      if (b == CH_DOLLAR) begin
        in_sent = 1;
        xsum = 0;
        sum_rx = 0;
        blen = 0;
        tphase = TP_BODY;
        tail_bad = 0;
        return;
      end
      if (!in_sent) return;
      if (b == CH_LF) begin
        in_sent = 0;
        if (!tail_bad && (tphase == TP_CR || tphase == TP_TAIL) && sum_rx == xsum)
          if (build_record(r)) expected_recs.push_back(r);
        return;
      end
      case (tphase)
        TP_BODY: begin
          if (b == CH_STAR) tphase = TP_HEX1;
          else if (blen >= MAXL) in_sent = 0;
          else begin
            body[blen++] = b;
            xsum ^= b;
          end
        end
        TP_HEX1, TP_HEX2: begin
          h = hex_of(b);
          if (h < 0) tail_bad = 1;
          else begin
            sum_rx = {sum_rx[3:0], h[3:0]};
            tphase = (tphase == TP_HEX1) ? TP_HEX2 : TP_CR;
          end
        end
        TP_CR: begin
          if (b == CH_CR) tphase = TP_TAIL;
          else tail_bad = 1;
        end
        default: tail_bad = 1;
      endcase
    endfunction

    function void mismatch(string name, bit [63:0] e, bit [63:0] a);
      $error("%s: expected %h, got %h", name, e, a);
      errors++;
    endfunction

    // Compares one delivered record with the oldest expected one.
    function void check_record(rec_t got);
      rec_t e;
      records_seen++;
      if (expected_recs.size() == 0) begin
        $error("record delivered with none expected: %h", got);
        errors++;
        return;
      end
      e = expected_recs.pop_front();
      if (got.sentence_kind !== e.sentence_kind)
        mismatch("sentence_kind", e.sentence_kind, got.sentence_kind);
      if (got.date_time !== e.date_time) mismatch("date_time", e.date_time, got.date_time);
      if (got.fix_invalid !== e.fix_invalid)
        mismatch("fix_invalid", e.fix_invalid, got.fix_invalid);
      if (got.hemispheres !== e.hemispheres)
        mismatch("hemispheres", e.hemispheres, got.hemispheres);
      if (got.latitude_bcd !== e.latitude_bcd)
        mismatch("latitude_bcd", e.latitude_bcd, got.latitude_bcd);
      if (got.longitude_bcd !== e.longitude_bcd)
        mismatch("longitude_bcd", e.longitude_bcd, got.longitude_bcd);
      if (got.speed_bcd !== e.speed_bcd) mismatch("speed_bcd", e.speed_bcd, got.speed_bcd);
      if (got.course_bcd !== e.course_bcd)
        mismatch("course_bcd", e.course_bcd, got.course_bcd);
      if (got.satellites !== e.satellites)
        mismatch("satellites", e.satellites, got.satellites);
      if (got.altitude_bcd !== e.altitude_bcd)
        mismatch("altitude_bcd", e.altitude_bcd, got.altitude_bcd);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  nmea_in_if  in_ch();
  nmea_out_if out_ch();

  nmea_scoreboard sb = new();
  int  tx_gap_pct;
  int  rx_stall_pct;
  bit  hold_req;
  bit  burst;
  int  words_sent;

  nmea_rmc_gga_field_extractor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int r;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end else if (r >= rx_stall_pct) begin
        out_ch.ready <= 1'b1;
      end else if (r < 3) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
      end
    end
  end

  // Record monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_record({out_ch.sentence_kind, out_ch.date_time, out_ch.fix_invalid,
                       out_ch.hemispheres, out_ch.latitude_bcd, out_ch.longitude_bcd,
                       out_ch.speed_bcd, out_ch.course_bcd, out_ch.satellites,
                       out_ch.altitude_bcd});
  end

  // Offers one word and waits until it is taken, then maybe idles.
  task automatic send_word(input bit [7:0] b);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b);
    words_sent++;
    if (!burst && $urandom_range(0, 99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(0, 19) == 0) repeat ($urandom_range(10, 50)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  // Frames a body with '$', a tail of the given style (checksum or none) and line end.
  task automatic send_sentence(input string text, input tail_style_t style);
    bit [7:0] sum;
    sum = 0;
    for (int i = 0; i < text.len(); i++) sum ^= text[i];
    send_word(CH_DOLLAR);
    send_text(text);
    case (style)
      TL_NO_STAR:     ;
      TL_BAD_SUM:     send_text($sformatf("*%02X\r", sum ^ 8'(1 << $urandom_range(0, 7))));
      TL_LOWER_NO_CR: send_text($sformatf("*%02x", sum));
      TL_EXTRA:       send_text($sformatf("*%02X\r\r", sum));
      TL_BAD_HEX:     send_text($sformatf("*%1XG\r", sum[7:4]));
      default:        send_text($sformatf("*%02X\r", sum));
    endcase
    send_word(CH_LF);
  endtask

  // Waits until every expected record has come, then lets the pipe settle.
  task automatic drain();
    int n;
    n = 0;
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected records never came", sb.pending());
      sb.errors++;
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string pick(string a, string b, string c, string d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  function automatic string rnd_time();
    if ($urandom_range(0, 9) < 8)
      return $sformatf("%02d%02d%02d.%02d", $urandom_range(0, 23), $urandom_range(0, 59),
                       $urandom_range(0, 59), $urandom_range(0, 99));
    return pick(digits(6), "", digits(4), "2a0000");
  endfunction

  function automatic string rnd_date();
    int d;
    d = ($urandom_range(0, 1) == 0) ? $urandom_range(27, 31) : $urandom_range(1, 31);
    if ($urandom_range(0, 9) < 8)
      return $sformatf("%02d%02d%02d", d, $urandom_range(1, 12), $urandom_range(14, 98));
    return pick(digits(6), "", "311299", "001213");
  endfunction

  function automatic string rnd_angle(int degw, int maxdeg);
    string fmt;
    fmt = (degw == 2) ? "%02d%02d.%05d" : "%03d%02d.%05d";
    if ($urandom_range(0, 9) < 8)
      return $sformatf(fmt, $urandom_range(0, maxdeg), $urandom_range(0, 59),
                       $urandom_range(0, 99999));
    return pick("", $sformatf("%0d.%0d", $urandom_range(0, 9999), $urandom_range(0, 999)),
                (degw == 2) ? "9000.00001" : "18000.00000", "48x7.1");
  endfunction

  function automatic string rnd_decimal(int maxint);
    if ($urandom_range(0, 9) < 7)
      return $sformatf("%0d.%0d", $urandom_range(0, maxint), $urandom_range(0, 9));
    return pick(pick("", "12", ".3", "1.2.3"), "12345.6", "007.", digits(3));
  endfunction

  function automatic string rnd_rmc();
    return $sformatf("GNRMC,%s,%s,%s,%s,%s,%s,%s,%s,%s,,,A", rnd_time(),
                     pick("A", "V", "", "Ax"), rnd_angle(2, 90), pick("N", "S", "", "X"),
                     rnd_angle(3, 180), pick("E", "W", "", "Q"), rnd_decimal(200),
                     rnd_decimal(400), rnd_date());
  endfunction

  function automatic string rnd_gga();
    string sats, alt;
    sats = ($urandom_range(0, 3) != 0) ? $sformatf("%0d", $urandom_range(0, 99))
                                       : pick("", "1a", "123", "07");
    alt = ($urandom_range(0, 3) != 0)
        ? $sformatf("%s%0d.%0d", pick("-", "", "", ""), $urandom_range(0, 9999),
                    $urandom_range(0, 9))
        : pick("", "12", "12345.6", "-1.");
    return $sformatf("GNGGA,%s,%s,%s,%s,%s,1,%s,0.9,%s,M,46.9,M,,", rnd_time(),
                     rnd_angle(2, 90), pick("N", "S", "N", "S"), rnd_angle(3, 180),
                     pick("E", "W", "E", "W"), sats, alt);
  endfunction

  // Main stimulus.
  initial begin
    int kind;
    int loops;
    string s;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    hold_req     = 0;
    burst        = 0;
    words_sent   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sentences: extremes, rollovers, gates and malformed tails.
    send_sentence("GNRMC,235959.99,A,9000.00000,N,18000.00000,W,137.9,361.9,311298,,,A",
                  TL_GOOD);
    send_sentence("GNRMC,160000,A,0000.00000,S,00000.00000,E,0.0,0.0,280216,,,A", TL_GOOD);
    send_sentence("GNRMC,165959,V,9000.00001,N,12000.0,E,138.0,362.0,300417,,,A",
                  TL_LOWER_NO_CR);
    send_sentence("GNRMC,000000,,4807.038,X,01131.000,E,1234.5,.5,010114,,,A", TL_GOOD);
    send_sentence("GNRMC,12a456,A,,N,,E,12345.6,1234.5,310499,,,A", TL_GOOD);
    send_sentence("GNRMC,,,,,,,99,,,,,", TL_GOOD);
    send_sentence("GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,-545.4,M,46.9,M,,", TL_GOOD);
    send_sentence("GNGGA,,,,,,,9,,12345.6,,,,", TL_GOOD);
    send_sentence("GNGGA,,,,,,,123,,-1.,,,,", TL_GOOD);
    send_sentence("GNGGA,,,,,,,1a,,5,,,,", TL_GOOD);
    send_sentence("GNRMC,,,,,,,,,,", TL_GOOD);
    send_sentence("GPRMC,,,,,,,,,,,,", TL_GOOD);
    send_sentence("GNGGA,,,,,,,5,,1.0,,,,", TL_BAD_SUM);
    send_sentence("GNGGA,,,,,,,5,,1.0,,,,", TL_EXTRA);
    send_sentence("GNGGA,,,,,,,5,,1.0,,,,", TL_BAD_HEX);
    send_sentence("GNGGA,,,,,,,5,,1.0,,,,", TL_NO_STAR);
    send_sentence({"GNGGA,,,,,,,5,,1.0,,,,", digits(120)}, TL_GOOD);
    send_text("$GNRMC,1234");
    send_sentence("GNGGA,,,,,,,42,,9999.9,,,,", TL_GOOD);
    send_word(8'hff);
    send_word(8'h00);
    send_word(CH_LF);
    drain();

    // Long hold-off on the result side while sentences keep coming.
    hold_req = 1;
    burst = 1;
    for (int i = 0; i < 6; i++) send_sentence(rnd_gga(), TL_GOOD);
    burst = 0;
    drain();

    // Random sentences, mostly well formed, with noise and broken framing.
    loops = 0;
    while ((words_sent < 600 || sb.records_seen < 60) && loops < 2000) begin
      loops++;
      case (loops % 150)
        0:  begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        40: begin tx_gap_pct = 20; rx_stall_pct = 20; end
        90: begin tx_gap_pct = 50; rx_stall_pct = 60; end
        default: ;
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 40) send_sentence(rnd_rmc(), TL_GOOD);
      else if (kind < 70) send_sentence(rnd_gga(), TL_GOOD);
      else if (kind < 76) send_sentence(rnd_rmc(), TL_LOWER_NO_CR);
      else if (kind < 82) begin
        s = ($urandom_range(0, 1) != 0) ? rnd_rmc() : rnd_gga();
        send_sentence(s, tail_style_t'($urandom_range(TL_BAD_SUM, TL_NO_STAR)));
      end else if (kind < 86) begin
        s = rnd_rmc();
        send_sentence(s.substr(0, $urandom_range(5, s.len() - 1)), TL_GOOD);
      end else if (kind < 89) begin
        send_sentence({rnd_gga(), digits($urandom_range(60, 100))}, TL_GOOD);
      end else if (kind < 93) begin
        send_text({"$", rnd_rmc().substr(0, $urandom_range(0, 30))});
      end else begin
        repeat ($urandom_range(1, 20)) send_word(8'($urandom_range(0, 255)));
      end
      if (loops % 97 == 0) drain();
    end

    in_ch.valid <= 1'b0;
    drain();
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/nmea_pkg.sv
rtl/nmea_in_if.sv
rtl/nmea_out_if.sv
rtl/nmea_front.sv
rtl/nmea_queue.sv
rtl/nmea_back.sv
rtl/nmea_rmc_gga_field_extractor.sv
tb/nmea_rmc_gga_field_extractor_tb.sv
